@@ rtl/core/nmdd_pkg.sv @@
// Shared constants and types of the neighbour max difference density core.
package nmdd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 128;

    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int POS_W      = X_W + Y_W;
    localparam int CELLS_W    = POS_W + 1;
    localparam int DIFF_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int LINE_AW    = 2 + X_W;
    localparam int LINE_DEPTH = 3 * (2 ** X_W);

    localparam int GW_W       = 9;
    localparam int GH_W       = 8;
    localparam int RHO_W      = 17;
    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = 33;
    localparam int QUO_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int STEP_W     = 4;

    localparam logic [RHO_W-1:0] ONE_Q16 = RHO_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RHO     = CFG_IDX_W'(2);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] rem_init;
        logic [QUO_W-1:0]  numer;
        logic [DIFF_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
        logic [DIFF_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/core/neighbour_max_difference_density_core.sv @@
// Top level of the neighbour max difference density core.
// Takes one transaction at a time: start is taken when busy is low. After reset the
// difference memory is cleared with busy high; configuration writes are taken
// throughout. A load on the grid border goes straight to the write-back; an interior
// load first makes the eight one-port reads of the three-row line memory. The first
// load after a change of grid_width or grid_height also waits for a position divide.
// An emit uses the bit-serial divider when the value lies below the grid maximum; its
// result shows for one cycle with result_valid and cannot be held off, and the next
// start may come in that same cycle.
module neighbour_max_difference_density_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic signed [nmdd_pkg::SAMPLE_W-1:0] sample,
    output logic                           result_valid,
    output logic [nmdd_pkg::RHO_W-1:0]     density,
    output logic                           density_last,
    input  logic                           cfg_we,
    input  logic [nmdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nmdd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nmdd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLEAR = 9'b000000010,
        ST_POS   = 9'b000000100,
        ST_LOAD  = 9'b000001000,
        ST_NB    = 9'b000010000,
        ST_LWR   = 9'b000100000,
        ST_ERD   = 9'b001000000,
        ST_EDIV  = 9'b010000000,
        ST_EWAIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [GW_W-1:0]     gw_reg, gw_next;
    logic [GH_W-1:0]     gh_reg, gh_next;
    logic [RHO_W-1:0]    rho_reg, rho_next;
    logic                dirty_reg, dirty_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [POS_W-1:0]    p_reg, p_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [POS_W-1:0]    e_reg, e_next;
    logic [DIFF_W-1:0]   max_reg, max_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic                interior_reg, interior_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SAMPLE_W-1:0] c_reg, c_next;
    logic [DIFF_W-1:0]   val_reg, val_next;
    logic [POS_W-1:0]    clr_reg, clr_next;
    logic [RHO_W-1:0]    dens_reg, dens_next;
    logic                last_reg, last_next;
    logic                rv_reg, rv_next;

    logic [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] line_q_reg;
    logic                line_we;
    logic [LINE_AW-1:0]  line_waddr, line_raddr;
    logic [DIFF_W-1:0]   diff_mem [DIFF_DEPTH];
    logic [DIFF_W-1:0]   diff_q_reg;
    logic                diff_we;
    logic [POS_W-1:0]    diff_waddr, diff_raddr;
    logic [DIFF_W-1:0]   diff_wdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [GW_W-1:0]    w_eff;
    logic [GH_W-1:0]    h_eff;
    logic [CELLS_W-1:0] cells;
    logic [RHO_W-1:0]   mr;
    logic [POS_W-1:0]   p_clamp, e_clamp;
    logic [1:0]         r0, r1, r2;
    logic [Y_W-1:0]     row_sel;
    logic [GW_W-1:0]    col_sel;
    logic [X_W-1:0]     xm1, xm2;
    logic [DIFF_W-1:0]  d_cur, v_fin;
    logic [RHO_W-1:0]   q_div;
    logic               accept;

    function automatic logic [1:0] mod3(input logic [Y_W-1:0] v);
        logic [Y_W+8:0] prod;
        logic [Y_W-1:0] q;
        logic [Y_W+1:0] r;
        prod = (Y_W+9)'(v) * (Y_W+9)'(171);
        q    = Y_W'(prod >> 9);
        r    = (Y_W+2)'(v) - (Y_W+2)'(q) * (Y_W+2)'(3);
        if (r >= (Y_W+2)'(3))
        begin
            r = r - (Y_W+2)'(3);
        end
        return r[1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    nmdd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        w_eff = gw_reg;
        if (gw_reg < GW_W'(3))
        begin
            w_eff = GW_W'(3);
        end
        else if (gw_reg > GW_W'(MAX_WIDTH))
        begin
            w_eff = GW_W'(MAX_WIDTH);
        end
        h_eff = gh_reg;
        if (gh_reg < GH_W'(3))
        begin
            h_eff = GH_W'(3);
        end
        else if (gh_reg > GH_W'(MAX_HEIGHT))
        begin
            h_eff = GH_W'(MAX_HEIGHT);
        end
        cells   = CELLS_W'(w_eff * h_eff);
        mr      = (rho_reg > ONE_Q16) ? ONE_Q16 : rho_reg;
        p_clamp = (CELLS_W'(p_reg) < cells) ? p_reg : '0;
        e_clamp = (CELLS_W'(e_reg) < cells) ? e_reg : '0;
        r0      = mod3(y_reg);
        r1      = mod3(y_reg - 1'b1);
        r2      = mod3(y_reg - Y_W'(2));
        xm1     = x_reg - 1'b1;
        xm2     = x_reg - X_W'(2);
        d_cur   = abs_diff(c_reg, line_q_reg);
        v_fin   = val_reg;
        if (abs_diff(c_reg, sample_reg) > val_reg)
        begin
            v_fin = abs_diff(c_reg, sample_reg);
        end
        q_div   = {1'b0, div_rsp.quo};
        if (q_div < mr)
        begin
            q_div = mr;
        end
        if (y_reg == '0)
        begin
            row_sel = Y_W'(h_eff - 1'b1);
            col_sel = GW_W'(x_reg);
        end
        else if (x_reg < X_W'(2))
        begin
            row_sel = y_reg - 1'b1;
            col_sel = w_eff - GW_W'(2) + GW_W'(x_reg);
        end
        else
        begin
            row_sel = y_reg - 1'b1;
            col_sel = GW_W'(xm2);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        gw_next       = gw_reg;
        gh_next       = gh_reg;
        rho_next      = rho_reg;
        dirty_next    = dirty_reg;
        sample_next   = sample_reg;
        p_next        = p_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        e_next        = e_reg;
        max_next      = max_reg;
        idx_next      = idx_reg;
        interior_next = interior_reg;
        step_next     = step_reg;
        c_next        = c_reg;
        val_next      = val_reg;
        clr_next      = clr_reg;
        dens_next     = dens_reg;
        last_next     = last_reg;
        rv_next       = 1'b0;
        line_we       = 1'b0;
        line_waddr    = {r0, x_reg};
        line_raddr    = {r1, xm1};
        diff_we       = 1'b0;
        diff_waddr    = idx_reg;
        diff_wdata    = '0;
        diff_raddr    = e_reg;
        div_req       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                diff_we    = 1'b1;
                diff_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == POS_W'(DIFF_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LOAD)
                    begin
                        sample_next = sample;
                        p_next      = p_clamp;
                        if (dirty_reg)
                        begin
                            div_req.start    = 1'b1;
                            div_req.rem_init = '0;
                            div_req.numer    = QUO_W'(p_clamp);
                            div_req.divisor  = DIFF_W'(w_eff);
                            state_next       = ST_POS;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_POS:
            begin
                if (div_rsp.done)
                begin
                    x_next     = div_rsp.rem[X_W-1:0];
                    y_next     = div_rsp.quo[Y_W-1:0];
                    dirty_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (p_reg == '0)
                begin
                    max_next = '0;
                end
                line_we       = 1'b1;
                idx_next      = POS_W'(row_sel * w_eff + col_sel);
                interior_next = (y_reg >= Y_W'(2)) && (x_reg >= X_W'(2));
                val_next      = '0;
                step_next     = '0;
                state_next    = ((y_reg >= Y_W'(2)) && (x_reg >= X_W'(2))) ? ST_NB : ST_LWR;
            end
            ST_NB:
            begin
                case (step_reg)
                    STEP_W'(0): line_raddr = {r1, xm1};
                    STEP_W'(1): line_raddr = {r2, xm2};
                    STEP_W'(2): line_raddr = {r2, xm1};
                    STEP_W'(3): line_raddr = {r2, x_reg};
                    STEP_W'(4): line_raddr = {r1, xm2};
                    STEP_W'(5): line_raddr = {r1, x_reg};
                    STEP_W'(6): line_raddr = {r0, xm2};
                    default:    line_raddr = {r0, xm1};
                endcase
                if (step_reg == STEP_W'(1))
                begin
                    c_next = line_q_reg;
                end
                else if (step_reg != '0)
                begin
                    if (d_cur > val_reg)
                    begin
                        val_next = d_cur;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(8))
                begin
                    state_next = ST_LWR;
                end
            end
            ST_LWR:
            begin
                diff_we = 1'b1;
                if (interior_reg)
                begin
                    diff_wdata = v_fin;
                    if (v_fin > max_reg)
                    begin
                        max_next = v_fin;
                    end
                end
                if (CELLS_W'(p_reg) + 1'b1 >= cells)
                begin
                    p_next = '0;
                    x_next = '0;
                    y_next = '0;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    if (GW_W'(x_reg) == w_eff - 1'b1)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_ERD:
            begin
                e_next     = e_clamp;
                diff_raddr = e_clamp;
                state_next = ST_EDIV;
            end
            ST_EDIV:
            begin
                if (max_reg == '0)
                begin
                    dens_next = mr;
                end
                else if (diff_q_reg >= max_reg)
                begin
                    dens_next = ONE_Q16;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = diff_q_reg;
                    div_req.numer    = '0;
                    div_req.divisor  = max_reg;
                end
                if (max_reg == '0 || diff_q_reg >= max_reg)
                begin
                    rv_next    = 1'b1;
                    last_next  = (CELLS_W'(e_reg) == cells - 1'b1);
                    e_next     = (CELLS_W'(e_reg) + 1'b1 >= cells) ? '0 : e_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EWAIT;
                end
            end
            ST_EWAIT:
            begin
                if (div_rsp.done)
                begin
                    dens_next  = q_div;
                    rv_next    = 1'b1;
                    last_next  = (CELLS_W'(e_reg) == cells - 1'b1);
                    e_next     = (CELLS_W'(e_reg) + 1'b1 >= cells) ? '0 : e_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:
                begin
                    gw_next    = cfg_data[GW_W-1:0];
                    dirty_next = 1'b1;
                end
                REG_GRID_HEIGHT:
                begin
                    gh_next    = cfg_data[GH_W-1:0];
                    dirty_next = 1'b1;
                end
                REG_MIN_RHO:
                begin
                    rho_next = cfg_data[RHO_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            gw_reg    <= GW_W'(256);
            gh_reg    <= GH_W'(128);
            rho_reg   <= '0;
            dirty_reg <= 1'b0;
            p_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            e_reg     <= '0;
            max_reg   <= '0;
            step_reg  <= '0;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gw_reg    <= gw_next;
            gh_reg    <= gh_next;
            rho_reg   <= rho_next;
            dirty_reg <= dirty_next;
            p_reg     <= p_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            e_reg     <= e_next;
            max_reg   <= max_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        idx_reg      <= idx_next;
        interior_reg <= interior_next;
        c_reg        <= c_next;
        val_reg      <= val_next;
        dens_reg     <= dens_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= sample_reg;
        end
        line_q_reg <= line_mem[line_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (diff_we)
        begin
            diff_mem[diff_waddr] <= diff_wdata;
        end
        diff_q_reg <= diff_mem[diff_raddr];
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign density      = dens_reg;
    assign density_last = last_reg;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> density <= ONE_Q16)
        else $error("density above one");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_LOAD) |=> !result_valid ##1 !result_valid)
        else $error("load transaction produced a result");

    a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_POS || state_reg == ST_EWAIT))
        else $error("divider finished outside a waiting state");
`endif

endmodule

@@ rtl/core/nmdd_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by position and density.
module nmdd_div (
    input  logic             clk,
    input  logic             rst_n,
    input  nmdd_pkg::div_req_t req,
    output nmdd_pkg::div_rsp_t rsp
);
    import nmdd_pkg::*;

    logic [DIFF_W-1:0] rem_reg, rem_next;
    logic [DIFF_W-1:0] div_reg, div_next;
    logic [QUO_W-1:0]  numer_reg, numer_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W:0]   cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIFF_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial      = {rem_reg, numer_reg[QUO_W-1]};
        ge         = trial >= {1'b0, div_reg};
        rem_next   = rem_reg;
        div_next   = div_reg;
        numer_next = numer_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            rem_next   = req.rem_init;
            div_next   = req.divisor;
            numer_next = req.numer;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next   = ge ? DIFF_W'(trial - {1'b0, div_reg}) : DIFF_W'(trial);
            numer_next = {numer_reg[QUO_W-2:0], 1'b0};
            quo_next   = {quo_reg[QUO_W-2:0], ge};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == (STEP_W+1)'(QUO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        numer_reg <= numer_next;
        quo_reg   <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
